>>> rtl/sww_pkg.sv
// Package with the word types and constants of the smoothness weight window core.
package sww_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned WeightOne   = 32768;
  localparam int unsigned DWidth      = 45;

  typedef struct packed {
    logic [15:0] sample;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic [15:0] weight;
    logic [11:0] center_col;
    logic [15:0] center_row;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StSum,
    StCalc,
    StOut
  } state_e;

  typedef struct packed {
    logic        start;
    logic [44:0] d;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] weight;
  } root_rsp_t;

endpackage

>>> rtl/sww_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sww_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/sww_root.sv
// Iterative search for the weight: bisection, each step computed as a sequence of phases.
module sww_root (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sww_pkg::root_req_t req_i,
  output sww_pkg::root_rsp_t rsp_o
);

  // Per step: mid, then mid^2, then mid^4 (a 32-bit and a 64-bit product), then mid^4 * 441 >> 36, compare.
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [55:0] tgt_q, tgt_d;
  logic [2:0]  ph_q, ph_d;
  logic        busy_q, busy_d;
  logic [15:0] mid_q, mid_d;
  logic [31:0] sq_q, sq_d;
  logic [63:0] t4_q, t4_d;
  logic [55:0] sf_q, sf_d;
  logic        done_q, done_d;
  logic [15:0] res_q, res_d;
  logic [16:0] sum;

  assign sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    lo_d = lo_q; hi_d = hi_q; tgt_d = tgt_q; ph_d = ph_q; busy_d = busy_q;
    mid_d = mid_q; sq_d = sq_q; t4_d = t4_q; sf_d = sf_q;
    done_d = done_q; res_d = res_q;
    if (req_i.start) begin
      lo_d = '0; hi_d = 16'h8000; busy_d = 1'b1; ph_d = 3'd0; done_d = 1'b0;
      tgt_d = 56'(req_i.d) * 56'd625;
    end else if (busy_q) begin
      unique case (ph_q)
        3'd0: begin
          if (lo_q >= hi_q) begin
            busy_d = 1'b0; done_d = 1'b1;
            res_d = 16'(17'(sww_pkg::WeightOne) - {1'b0, lo_q});
          end else begin
            mid_d = sum[16:1]; ph_d = 3'd1;
          end
        end
        3'd1: begin sq_d = 32'(mid_q) * 32'(mid_q); ph_d = 3'd2; end
        3'd2: begin t4_d = 64'(sq_q) * 64'(sq_q); ph_d = 3'd3; end
        3'd3: begin
          sf_d = 56'(t4_q[63:36]) * 56'd441 + 56'((65'(t4_q[35:0]) * 65'd441) >> 36);
          ph_d = 3'd4;
        end
        default: begin
          if (sf_q >= tgt_q) hi_d = mid_q;
          else lo_d = mid_q + 16'd1;
          ph_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; ph_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; tgt_q <= tgt_d; mid_q <= mid_d;
    sq_q <= sq_d; t4_q <= t4_d; sf_q <= sf_d; res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.weight = res_q;

endmodule

>>> rtl/smoothness_weight_window_core.sv
// Top level: line-store memory, 5x5 window, moment sums and weight output.
//
//   channel | signals                   | word
//   in      | in_valid_i / in_ready_o   | sww_pkg::in_word_t
//   out     | out_valid_o / out_ready_i | sww_pkg::out_word_t
//   cfg     | cfg_valid_i / cfg_ready_o | line width, 13 bits
//
// A word without a result passes through the accept state and one memory read state.
// A word with a result passes through accept, read, 5 row sums, start, then
// up to 16 bisection steps and one finishing step in the root unit.
// A full output register holds the core in the output state, once its result is ready, until the waiting word is taken.
// Reset clears the column and row counters and the window; the line store is not cleared.
module smoothness_weight_window_core #(
  parameter int unsigned MaxWidth = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sww_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sww_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [12:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxWidth);

  sww_pkg::state_e state_q, state_d;
  logic [12:0] width_q;
  logic [AW:0] col_q, col_d, col_cur_q, wcl;
  logic [15:0] row_q, row_cur_q;
  logic [15:0] smp_q;
  logic [15:0] win_q [25];
  logic [63:0] rd, wd;
  logic        we;
  logic [2:0]  rc_q;
  logic        outer_row;
  logic [4:0]  base, idx;
  logic [18:0] rs1;
  logic [34:0] rs2;
  logic [20:0] s1_q;
  logic [36:0] s2_q;
  logic        have_res_q;
  sww_pkg::root_req_t req;
  sww_pkg::root_rsp_t rsp;
  sww_pkg::out_word_t ow_q;
  logic        ov_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (width_q < 13'd5) wcl = (AW+1)'(5);
    else if (32'(width_q) > MaxWidth) wcl = (AW+1)'(MaxWidth);
    else wcl = (AW+1)'(width_q);
  end

  assign in_ready_o = (state_q == sww_pkg::StIdle);

  always_comb begin
    col_d = col_q;
    if (in_word_i.frame_start) col_d = '0;
    if (col_d >= wcl) col_d = '0;
  end

  sww_ram #(.Width(64), .Depth(MaxWidth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(col_cur_q[AW-1:0]), .wdata_i(wd),
    .raddr_i(col_d[AW-1:0]), .rdata_o(rd)
  );

  assign we = (state_q == sww_pkg::StRead);
  assign wd = {rd[47:0], smp_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sww_pkg::StIdle: if (in_valid_i) state_d = sww_pkg::StRead;
      sww_pkg::StRead: state_d = have_res_q ? sww_pkg::StSum : sww_pkg::StIdle;
      sww_pkg::StSum: if (rc_q == 3'd4) state_d = sww_pkg::StCalc;
      sww_pkg::StCalc: state_d = sww_pkg::StOut;
      sww_pkg::StOut: if (rsp.done && !ov_q) state_d = sww_pkg::StIdle;
      default: state_d = sww_pkg::StIdle;
    endcase
  end

  // One window row per cycle; the corners of the outer rows are left out.
  always_comb begin
    rs1 = '0; rs2 = '0;
    outer_row = (rc_q == 3'd0 || rc_q == 3'd4);
    base = {2'b00, rc_q} * 5'd5;
    idx = base;
    for (int c = 0; c < 5; c++) begin
      idx = base + 5'(c);
      if (!(outer_row && (c == 0 || c == 4))) begin
        rs1 = rs1 + 19'(win_q[idx]);
        rs2 = rs2 + 35'(32'(win_q[idx]) * 32'(win_q[idx]));
      end
    end
  end

  assign req.start = (state_q == sww_pkg::StCalc);
  assign req.d = 45'(45'(s2_q) * 45'd21 - 45'(s1_q) * 45'(s1_q));

  sww_root u_root (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sww_pkg::StIdle; width_q <= 13'd4096; col_q <= '0; row_q <= '0;
      ov_q <= 1'b0; have_res_q <= 1'b0;
      for (int i = 0; i < 25; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) width_q <= cfg_data_i;
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (state_q == sww_pkg::StOut && rsp.done && !ov_q) ov_q <= 1'b1;
      if (state_q == sww_pkg::StIdle && in_valid_i) begin
        have_res_q <= !in_word_i.frame_start && row_q >= 16'd4 && col_d >= (AW+1)'(4);
        if (col_d + (AW+1)'(1) >= wcl) begin
          col_q <= '0;
          if (in_word_i.frame_start) row_q <= 16'd1;
          else if (row_q != 16'hFFFF) row_q <= row_q + 16'd1;
        end else begin
          col_q <= col_d + (AW+1)'(1);
          if (in_word_i.frame_start) row_q <= '0;
        end
      end
      if (state_q == sww_pkg::StRead) begin
        for (int r = 0; r < 5; r++) begin
          for (int c = 0; c < 4; c++) win_q[r*5+c] <= win_q[r*5+c+1];
        end
        win_q[4] <= rd[63:48]; win_q[9] <= rd[47:32];
        win_q[14] <= rd[31:16]; win_q[19] <= rd[15:0]; win_q[24] <= smp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sww_pkg::StIdle && in_valid_i) begin
      smp_q <= in_word_i.sample;
      col_cur_q <= col_d;
      row_cur_q <= in_word_i.frame_start ? 16'd0 : row_q;
    end
    if (state_q == sww_pkg::StRead) begin
      s1_q <= '0; s2_q <= '0; rc_q <= '0;
    end else if (state_q == sww_pkg::StSum) begin
      s1_q <= s1_q + 21'(rs1); s2_q <= s2_q + 37'(rs2); rc_q <= rc_q + 3'd1;
    end
    if (state_q == sww_pkg::StOut && rsp.done && !ov_q) begin
      ow_q.weight     <= rsp.weight;
      ow_q.center_col <= 12'(col_cur_q - (AW+1)'(2));
      ow_q.center_row <= row_cur_q - 16'd2;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

endmodule
